// ===== rtl/ssrch_pkg.sv =====
package ssrch_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned NEEDLE_MAX_DEF    = 16;
  localparam int unsigned POSITION_BITS_DEF = 32;

  // Fixed field widths
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned LEN_CFG_W   = 5;
  localparam int unsigned MATCH_POS_W = 32;
  localparam int unsigned WORD_BYTES  = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_HIGH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOLD_MODE   = 2'd3;

  localparam logic [DATA_W-1:0] NUL_BYTE = 8'h00;
  localparam logic [DATA_W-1:0] UPPER_A  = 8'h41;
  localparam logic [DATA_W-1:0] UPPER_Z  = 8'h5A;
  localparam logic [DATA_W-1:0] CASE_GAP = 8'h20;

  // One result beat
  typedef struct packed {
    logic                   match_now;
    logic                   found;
    logic [MATCH_POS_W-1:0] match_position;
    logic                   run_end;
  } res_t;

  // ASCII lower-casing when folding is on
  function automatic logic [DATA_W-1:0] fold_byte(input logic [DATA_W-1:0] b,
                                                  input logic en);
    logic [DATA_W-1:0] r;
    r = b;
    if (en && (b >= UPPER_A) && (b <= UPPER_Z)) begin
      r = b + CASE_GAP;
    end
    return r;
  endfunction

endpackage

// ===== rtl/ssrch_cfg.sv =====
module ssrch_cfg #(
  parameter int unsigned NEEDLE_MAX = ssrch_pkg::NEEDLE_MAX_DEF,
  parameter int unsigned LEN_W      = $clog2(NEEDLE_MAX + 1)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [ssrch_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ssrch_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output logic [LEN_W-1:0]                       eff_len_o,
  output logic                                   fold_o,
  output logic [NEEDLE_MAX-1:0][ssrch_pkg::DATA_W-1:0] needle_o
);

  logic [ssrch_pkg::LEN_CFG_W-1:0]  len_q;
  logic [ssrch_pkg::CFG_DATA_W-1:0] low_q;
  logic [ssrch_pkg::CFG_DATA_W-1:0] high_q;
  logic                             fold_q;

  // Register file, write only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      low_q  <= '0;
      high_q <= '0;
      fold_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ssrch_pkg::REG_NEEDLE_LEN:  len_q  <= cfg_data_i[ssrch_pkg::LEN_CFG_W-1:0];
        ssrch_pkg::REG_NEEDLE_LOW:  low_q  <= cfg_data_i;
        ssrch_pkg::REG_NEEDLE_HIGH: high_q <= cfg_data_i;
        ssrch_pkg::REG_FOLD_MODE:   fold_q <= cfg_data_i[0];
      endcase
    end
  end

  // Needle bytes; bytes past the two words read as zero
  logic [NEEDLE_MAX-1:0][ssrch_pkg::DATA_W-1:0] raw;

  always_comb begin
    for (int i = 0; i < NEEDLE_MAX; i++) begin
      if (i < ssrch_pkg::WORD_BYTES) begin
        raw[i] = low_q[i*ssrch_pkg::DATA_W +: ssrch_pkg::DATA_W];
      end else if (i < 2 * ssrch_pkg::WORD_BYTES) begin
        raw[i] = high_q[(i - ssrch_pkg::WORD_BYTES)*ssrch_pkg::DATA_W +: ssrch_pkg::DATA_W];
      end else begin
        raw[i] = ssrch_pkg::NUL_BYTE;
      end
      needle_o[i] = ssrch_pkg::fold_byte(raw[i], fold_q);
    end
  end

  // Effective length: clamp, then cut at the first zero byte in string mode
  always_comb begin
    int clamp;
    int eff;
    clamp = (int'(len_q) > NEEDLE_MAX) ? NEEDLE_MAX : int'(len_q);
    eff   = clamp;
    for (int i = NEEDLE_MAX - 1; i >= 0; i--) begin
      if (fold_q && (i < clamp) && (raw[i] == ssrch_pkg::NUL_BYTE)) begin
        eff = i;
      end
    end
    eff_len_o = LEN_W'(eff);
  end

  assign fold_o = fold_q;

endmodule

// ===== rtl/ssrch_core.sv =====
module ssrch_core #(
  parameter int unsigned NEEDLE_MAX    = ssrch_pkg::NEEDLE_MAX_DEF,
  parameter int unsigned POSITION_BITS = ssrch_pkg::POSITION_BITS_DEF,
  parameter int unsigned LEN_W         = $clog2(NEEDLE_MAX + 1)
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         step_i,
  input  logic [ssrch_pkg::DATA_W-1:0]                 byte_i,
  input  logic                                         last_i,
  input  logic [LEN_W-1:0]                             eff_len_i,
  input  logic                                         fold_i,
  input  logic [NEEDLE_MAX-1:0][ssrch_pkg::DATA_W-1:0] needle_i,
  output ssrch_pkg::res_t                              res_o
);

  localparam int unsigned IDX_W = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
  localparam int unsigned EXT_W = POSITION_BITS + 1;
  localparam int unsigned WIDE_W = 64;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [NEEDLE_MAX-1:0][ssrch_pkg::DATA_W-1:0] win_q;
  logic [NEEDLE_MAX-1:0][ssrch_pkg::DATA_W-1:0] win_new;
  logic [POSITION_BITS-1:0] pos_q;
  logic [POSITION_BITS-1:0] start_q;
  logic [POSITION_BITS-1:0] start_new;
  logic [POSITION_BITS-1:0] start_now;
  logic                     found_q;
  logic                     ended_q;
  logic                     zero_term;
  logic                     all_eq;
  logic                     span_ok;
  logic                     match;
  logic                     found_now;
  logic [EXT_W-1:0]         pos_ext;
  logic [EXT_W-1:0]         len_ext;
  logic [EXT_W-1:0]         start_ext;
  logic [WIDE_W-1:0]        start_wide;

  // Window after this byte shifts in, entry 0 newest
  always_comb begin
    win_new[0] = byte_i;
    for (int j = 1; j < NEEDLE_MAX; j++) begin
      win_new[j] = win_q[j-1];
    end
  end

  // Compare every window entry in use against its aligned needle byte
  always_comb begin
    all_eq = 1'b1;
    for (int j = 0; j < NEEDLE_MAX; j++) begin
      if (j < int'(eff_len_i)) begin
        if (ssrch_pkg::fold_byte(win_new[j], fold_i) !=
            needle_i[IDX_W'(int'(eff_len_i) - 1 - j)]) begin
          all_eq = 1'b0;
        end
      end
    end
  end

  assign zero_term = fold_i && (byte_i == ssrch_pkg::NUL_BYTE);
  assign pos_ext   = EXT_W'(pos_q) + EXT_W'(1);
  assign len_ext   = EXT_W'(eff_len_i);
  assign span_ok   = !ended_q && !zero_term && (pos_ext >= len_ext);
  assign start_ext = pos_ext - len_ext;
  // An empty needle always starts at offset 0
  assign start_new = (eff_len_i == '0) ? '0 : start_ext[POSITION_BITS-1:0];

  // First match only; an empty needle hits on the first byte
  always_comb begin
    if (found_q) begin
      match = 1'b0;
    end else if (eff_len_i == '0) begin
      match = (pos_q == '0);
    end else begin
      match = span_ok && all_eq;
    end
  end

  assign found_now  = found_q || match;
  assign start_now  = match ? start_new : start_q;
  assign start_wide = WIDE_W'(start_now);

  always_comb begin
    res_o.match_now      = match;
    res_o.found          = found_now;
    res_o.match_position = found_now ? start_wide[ssrch_pkg::MATCH_POS_W-1:0] : '0;
    res_o.run_end        = last_i;
  end

  // Run state, cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      pos_q   <= '0;
      start_q <= '0;
      found_q <= 1'b0;
      ended_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        win_q   <= '0;
        pos_q   <= '0;
        start_q <= '0;
        found_q <= 1'b0;
        ended_q <= 1'b0;
      end else begin
        win_q   <= win_new;
        pos_q   <= (pos_q == POS_MAX) ? pos_q : pos_q + POSITION_BITS'(1);
        start_q <= start_now;
        found_q <= found_now;
        ended_q <= ended_q || zero_term;
      end
    end
  end

  // Checks
  a_match_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && match) |-> !found_q)
    else $error("match reported after the first one");

  a_found_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && found_q && !last_i) |=> found_q)
    else $error("found dropped inside a run");

  a_pos_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !last_i) |=> (pos_q != '0))
    else $error("position did not advance");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && last_i) |=> (!found_q && !ended_q && pos_q == '0))
    else $error("run state not cleared after last byte");

endmodule

// ===== rtl/substring_search_stream.sv =====
// A byte accepted into the input register is compared and then held in the result register.
// Throughput: one byte per cycle unless out_ready_i stalls; an input register and a result register
// split the two handshakes, and the window compare sits between them.
// Reset (rst_ni low, asynchronous): needle length 0, needle bytes 0,
// case folding on, run state and both pipeline registers empty.
module substring_search_stream #(
  parameter int unsigned NEEDLE_MAX    = ssrch_pkg::NEEDLE_MAX_DEF,
  parameter int unsigned POSITION_BITS = ssrch_pkg::POSITION_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ssrch_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ssrch_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [ssrch_pkg::DATA_W-1:0]         data_byte_i,
  input  logic                                 is_last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 match_now_o,
  output logic                                 found_o,
  output logic [ssrch_pkg::MATCH_POS_W-1:0]    match_position_o,
  output logic                                 run_end_o
);

  localparam int unsigned LEN_W = $clog2(NEEDLE_MAX + 1);

  logic [LEN_W-1:0]                             eff_len;
  logic                                         fold;
  logic [NEEDLE_MAX-1:0][ssrch_pkg::DATA_W-1:0] needle;

  logic                         in_vld_q;
  logic [ssrch_pkg::DATA_W-1:0] in_byte_q;
  logic                         in_last_q;
  logic                         out_vld_q;
  logic                         out_free;
  logic                         step;
  ssrch_pkg::res_t              res;
  ssrch_pkg::res_t              res_q;

  ssrch_cfg #(
    .NEEDLE_MAX (NEEDLE_MAX),
    .LEN_W      (LEN_W)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .eff_len_o  (eff_len),
    .fold_o     (fold),
    .needle_o   (needle)
  );

  // Handshake: result slot free when empty or draining this cycle
  assign out_free   = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= data_byte_i;
      in_last_q <= is_last_i;
    end
  end

  ssrch_core #(
    .NEEDLE_MAX    (NEEDLE_MAX),
    .POSITION_BITS (POSITION_BITS),
    .LEN_W         (LEN_W)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .eff_len_i (eff_len),
    .fold_i    (fold),
    .needle_i  (needle),
    .res_o     (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign match_now_o      = res_q.match_now;
  assign found_o          = res_q.found;
  assign match_position_o = res_q.match_position;
  assign run_end_o        = res_q.run_end;

  // Checks
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_free) |-> !in_ready_o)
    else $error("input taken while pipeline stalled");

  a_fill_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("processed beat lost before result register");

endmodule

// ===== tb/ssrch_checker.sv =====
`timescale 1ns / 1ps

module ssrch_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ssrch_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ssrch_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [ssrch_pkg::DATA_W-1:0]        data_byte_i,
  input  logic                                is_last_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic                                match_now_i,
  input  logic                                found_i,
  input  logic [ssrch_pkg::MATCH_POS_W-1:0]   match_position_i,
  input  logic                                run_end_i,
  output int unsigned                         pending_o,
  output int unsigned                         fail_count_o
);
  import ssrch_pkg::*;

  localparam int unsigned     NMAX      = NEEDLE_MAX_DEF;
  localparam longint unsigned POS_LIMIT = (64'd1 << POSITION_BITS_DEF) - 64'd1;

  // Needle setup as last written
  logic [LEN_CFG_W-1:0]  needle_len;
  logic [CFG_DATA_W-1:0] needle_lo;
  logic [CFG_DATA_W-1:0] needle_hi;
  logic                  fold_on;

  // Per-haystack search state
  logic [DATA_W-1:0] window [NMAX];
  longint unsigned   byte_pos;
  longint unsigned   first_start;
  logic              found_q;
  logic              zero_seen;

  res_t        search_results_q [$];
  int unsigned fails = 0;

  function automatic logic [DATA_W-1:0] needle_at(input int unsigned i);
    if (i < WORD_BYTES) return needle_lo[8*i +: 8];
    if (i < 2*WORD_BYTES) return needle_hi[8*(i-WORD_BYTES) +: 8];
    return NUL_BYTE;
  endfunction

  function automatic logic [DATA_W-1:0] folded(input logic [DATA_W-1:0] b);
    if (fold_on && b >= UPPER_A && b <= UPPER_Z) return b + CASE_GAP;
    return b;
  endfunction

  // Length after clamping, cut at the first zero byte in string mode
  function automatic int unsigned live_len();
    int unsigned len;
    int unsigned i;
    len = (needle_len > NMAX) ? NMAX : needle_len;
    if (fold_on) begin
      for (i = 0; i < len; i++) begin
        if (needle_at(i) == NUL_BYTE) return i;
      end
    end
    return len;
  endfunction

  function automatic void clear_run();
    int i;
    for (i = 0; i < NMAX; i++) window[i] = '0;
    byte_pos    = 0;
    first_start = 0;
    found_q     = 1'b0;
    zero_seen   = 1'b0;
  endfunction

  // Advance the search by one haystack byte and form its result beat
  task automatic search_step(input logic [DATA_W-1:0] b, input logic last,
                             output res_t r);
    int unsigned     len;
    longint unsigned offset;
    logic            hit;
    int              i;
    len    = live_len();
    offset = byte_pos;
    hit    = 1'b0;
    for (i = NMAX - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = b;

    if (!found_q) begin
      if (len == 0) begin
        if (offset == 0) begin
          hit         = 1'b1;
          first_start = 0;
        end
      end else if (!zero_seen && !(fold_on && b == NUL_BYTE) && offset + 1 >= len) begin
        hit = 1'b1;
        for (i = 0; i < len; i++) begin
          if (folded(window[len-1-i]) != folded(needle_at(i))) hit = 1'b0;
        end
        if (hit) first_start = offset + 1 - len;
      end
      if (hit) found_q = 1'b1;
    end

    if (fold_on && b == NUL_BYTE) zero_seen = 1'b1;
    if (byte_pos < POS_LIMIT) byte_pos++;

    r.match_now      = hit;
    r.found          = found_q;
    r.match_position = found_q ? first_start[MATCH_POS_W-1:0] : '0;
    r.run_end        = last;
    if (last) clear_run();
  endtask

  task automatic check_field(input string name, input logic [MATCH_POS_W-1:0] want,
                             input logic [MATCH_POS_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      fails++;
    end
  endtask

  // Track config writes, predict on accepted input beats, compare output beats
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      needle_len = '0;
      needle_lo  = '0;
      needle_hi  = '0;
      fold_on    = 1'b1;
      clear_run();
      search_results_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_NEEDLE_LEN:  needle_len = cfg_data_i[LEN_CFG_W-1:0];
          REG_NEEDLE_LOW:  needle_lo  = cfg_data_i;
          REG_NEEDLE_HIGH: needle_hi  = cfg_data_i;
          REG_FOLD_MODE:   fold_on    = cfg_data_i[0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (search_results_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, got match_now %0b found %0b pos %0h",
                   $time, match_now_i, found_i, match_position_i);
          fails++;
        end else begin
          want = search_results_q.pop_front();
          check_field("match_now", want.match_now, match_now_i);
          check_field("found", want.found, found_i);
          check_field("match_position", want.match_position, match_position_i);
          check_field("run_end", want.run_end, run_end_i);
        end
      end

      if (in_valid_i && in_ready_i) begin
        search_step(data_byte_i, is_last_i, want);
        search_results_q.push_back(want);
      end
    end
    pending_o    <= search_results_q.size();
    fail_count_o <= fails;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ssrch_pkg::*;

  localparam int unsigned NMAX       = NEEDLE_MAX_DEF;
  localparam int unsigned LATENCY    = 2;
  localparam int unsigned WDOG_LIMIT = 2000;
  localparam int unsigned RAND_BEATS = 850;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [DATA_W-1:0]      data_byte;
  logic                   is_last;
  logic                   out_valid;
  logic                   out_ready;
  logic                   match_now;
  logic                   found;
  logic [MATCH_POS_W-1:0] match_position;
  logic                   run_end;
  int unsigned            pending;
  int unsigned            fail_count;

  // Needle as currently programmed, used to build haystacks
  logic [LEN_CFG_W-1:0]  cur_len;
  logic [CFG_DATA_W-1:0] cur_lo;
  logic [CFG_DATA_W-1:0] cur_hi;
  logic                  cur_fold;

  logic [DATA_W-1:0] haystack [$];
  int unsigned       beats_sent = 0;
  int unsigned       idle_cycles = 0;
  bit                calm_in = 1'b0;
  bit                calm_out = 1'b0;

  substring_search_stream i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .data_byte_i      (data_byte),
    .is_last_i        (is_last),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .match_now_o      (match_now),
    .found_o          (found),
    .match_position_o (match_position),
    .run_end_o        (run_end)
  );

  ssrch_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .data_byte_i      (data_byte),
    .is_last_i        (is_last),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .match_now_i      (match_now),
    .found_i          (found),
    .match_position_i (match_position),
    .run_end_i        (run_end),
    .pending_o        (pending),
    .fail_count_o     (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random stall before each beat
  initial begin : result_sink
    int unsigned stall;
    out_ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = calm_out ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog on cycles without any beat or config write
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WDOG_LIMIT) begin
      $display("substring_search_stream: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [DATA_W-1:0] needle_at(input int unsigned i);
    return (i < WORD_BYTES) ? cur_lo[8*i +: 8] : cur_hi[8*(i-WORD_BYTES) +: 8];
  endfunction

  function automatic logic [DATA_W-1:0] flip_case(input logic [DATA_W-1:0] b);
    if ((b >= UPPER_A && b <= UPPER_Z) ||
        (b >= UPPER_A + CASE_GAP && b <= UPPER_Z + CASE_GAP)) return b ^ CASE_GAP;
    return b;
  endfunction

  // Letters plus the neighbors of both letter ranges, else any nonzero byte
  function automatic logic [DATA_W-1:0] pick_byte();
    case ($urandom_range(0, 13))
      0: return 8'h61;
      1: return 8'h41;
      2: return 8'h62;
      3: return 8'h42;
      4: return 8'h7A;
      5: return 8'h5A;
      6: return 8'h40;
      7: return 8'h5B;
      8: return 8'h60;
      9: return 8'h7B;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] filler(input int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 39);
    if (r == 0) return NUL_BYTE;
    if (span > 0 && r < 24) return needle_at($urandom_range(0, span - 1));
    return pick_byte();
  endfunction

  // Drive one input beat after a random gap, return at its accepting edge
  task automatic send_beat(input logic [DATA_W-1:0] b, input logic last);
    int unsigned gap;
    gap = calm_in ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    is_last   <= last;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic send_run();
    int unsigned k;
    for (k = 0; k < haystack.size(); k++) send_beat(haystack[k], k == haystack.size() - 1);
  endtask

  // Stop sending and let every outstanding result beat come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (LATENCY + 1) @(posedge clk);
  endtask

  // Write all four registers on back-to-back edges, junk in the unused bits
  task automatic program_needle(input logic [LEN_CFG_W-1:0] len, input logic [63:0] lo,
                                input logic [63:0] hi, input logic fold);
    logic [CFG_DATA_W-1:0] word;
    drain();
    word = {$urandom, $urandom};
    word[LEN_CFG_W-1:0] = len;
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_NEEDLE_LEN;
    cfg_data <= word;
    @(posedge clk);
    cfg_idx  <= REG_NEEDLE_LOW;
    cfg_data <= lo;
    @(posedge clk);
    cfg_idx  <= REG_NEEDLE_HIGH;
    cfg_data <= hi;
    @(posedge clk);
    word = {$urandom, $urandom};
    word[0] = fold;
    cfg_idx  <= REG_FOLD_MODE;
    cfg_data <= word;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_len  = len;
    cur_lo   = lo;
    cur_hi   = hi;
    cur_fold = fold;
  endtask

  task automatic pick_needle(input int unsigned phase);
    logic [DATA_W-1:0]    nbytes [NMAX];
    logic [63:0]          lo;
    logic [63:0]          hi;
    logic [LEN_CFG_W-1:0] len;
    logic                 fold;
    int                   i;
    for (i = 0; i < NMAX; i++) nbytes[i] = pick_byte();
    fold = 1'($urandom_range(0, 1));
    len  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 6));
    case (phase)
      0: begin
        len  = 5'd16;
        fold = 1'b0;
      end
      1: begin
        len  = 5'd31;
        fold = 1'b1;
      end
      2: begin
        len  = 5'd0;
        fold = 1'b0;
      end
      3: begin
        len  = 5'd16;
        fold = 1'b0;
        for (i = 0; i < NMAX; i++) nbytes[i] = 8'hFF;
      end
      4: begin
        // zeros are plain data in memory mode
        len  = 5'd8;
        fold = 1'b0;
        for (i = 0; i < NMAX; i++) nbytes[i] = NUL_BYTE;
      end
      5: begin
        // string mode needle cut down to nothing
        len       = 5'd5;
        fold      = 1'b1;
        nbytes[0] = NUL_BYTE;
      end
      default: begin
        if (fold && $urandom_range(0, 7) == 0) nbytes[$urandom_range(0, NMAX - 1)] = NUL_BYTE;
      end
    endcase
    lo = '0;
    hi = '0;
    for (i = 0; i < NMAX; i++) begin
      if (i < WORD_BYTES) lo[8*i +: 8] = nbytes[i];
      else hi[8*(i-WORD_BYTES) +: 8] = nbytes[i];
    end
    program_needle(len, lo, hi, fold);
  endtask

  // Mostly haystacks that hold the needle in random surroundings; also near
  // misses, terminators ahead of the needle, repeats, long runs and noise
  task automatic build_haystack();
    int unsigned      kind;
    int unsigned      span;
    int unsigned      n;
    int unsigned      k;
    logic [DATA_W-1:0] b;
    haystack.delete();
    span = (cur_len > NMAX) ? NMAX : cur_len;
    kind = $urandom_range(0, 19);
    if (kind >= 16) begin
      n = $urandom_range(1, 24);
      repeat (n) haystack.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = (kind == 15) ? $urandom_range(60, 200) : $urandom_range(0, 10);
      repeat (n) haystack.push_back(filler(span));
      if (kind == 14) haystack.push_back(NUL_BYTE);
      repeat ((kind == 12) ? 2 : 1) begin
        for (k = 0; k < span; k++) begin
          b = needle_at(k);
          if (cur_fold ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 7) == 0)) begin
            b = flip_case(b);
          end
          if (kind == 13 && k == span - 1) b = b + 8'd1;
          haystack.push_back(b);
        end
        n = $urandom_range(0, 6);
        repeat (n) haystack.push_back(filler(span));
      end
      if (haystack.size() == 0) haystack.push_back(filler(span));
    end
  endtask

  // Reset, directed cases, random phases, verdict
  initial begin : stimulus
    int unsigned rand_start;
    int unsigned phase;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= REG_NEEDLE_LEN;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    data_byte <= '0;
    is_last   <= 1'b0;
    cur_len   = '0;
    cur_lo    = '0;
    cur_hi    = '0;
    cur_fold  = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty needle after reset: hit at offset 0, even on a terminator
    haystack = '{NUL_BYTE};
    send_run();
    haystack = '{8'h41, 8'h42, 8'h43};
    send_run();

    // folded "aBc": first hit only, then nothing past a terminator
    program_needle(5'd3, 64'h0000_0000_0063_4261, 64'h0, 1'b1);
    haystack = '{8'h78, 8'h41, 8'h62, 8'h43, 8'h61, 8'h62, 8'h63};
    send_run();
    haystack = '{8'h78, NUL_BYTE, 8'h61, 8'h62, 8'h63};
    send_run();

    // memory mode: zero is ordinary needle and haystack data
    program_needle(5'd2, 64'h0000_0000_0000_FF00, 64'h0, 1'b0);
    haystack = '{NUL_BYTE, 8'hFF, 8'hFF};
    send_run();

    // string mode needle with an embedded zero is cut to one byte
    program_needle(5'd4, 64'h0000_0000_7A79_0078, 64'h0, 1'b1);
    haystack = '{8'h71, 8'h58};
    send_run();

    // memory mode is case sensitive
    program_needle(5'd2, 64'h0000_0000_0000_4261, 64'h0, 1'b0);
    haystack = '{8'h41, 8'h62, 8'h61, 8'h42};
    send_run();

    rand_start = beats_sent;
    phase      = 0;
    while (beats_sent - rand_start < RAND_BEATS) begin
      pick_needle(phase);
      calm_in  = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 8)) begin
        build_haystack();
        send_run();
      end
      phase++;
    end

    drain();
    if (fail_count == 0) begin
      $display("substring_search_stream: match");
    end else begin
      $display("substring_search_stream: mismatch");
    end
    $finish;
  end

endmodule
